@@ hdl/plit_pkg.sv @@
// ---------------------------------------------------------------------------
// plit_pkg
// shared constants, types and codes of the price level imbalance table
// ---------------------------------------------------------------------------
package plit_pkg;

  localparam int LEVELS  = 1024;
  localparam int SLOT_W  = $clog2(LEVELS);
  localparam int TICK_W  = 24;
  localparam int VOL_W   = 16;
  localparam int TOT_W   = 32;
  localparam int THR_W   = 8;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(29);

  // register indexes
  localparam logic CFG_BASE_TICK = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_OOR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [VOL_W-1:0]  bid;
    logic [VOL_W-1:0]  ask;
  } item_t;

  typedef struct packed {
    logic [TOT_W-1:0] bid_total;
    logic [TOT_W-1:0] ask_total;
    logic             buy;
    logic             sell;
    logic             oor;
  } result_t;

  localparam int ROW_W = 2 * TOT_W + 2;

endpackage

@@ hdl/plit_ram.sv @@
// ---------------------------------------------------------------------------
// plit_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module plit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/plit_front.sv @@
// ---------------------------------------------------------------------------
// plit_front
// classifies an incoming word: new bar, out of window, or add to a slot
// ---------------------------------------------------------------------------
module plit_front (
  input  logic                        in_command,
  input  logic [plit_pkg::TICK_W-1:0] in_price_tick,
  input  logic [plit_pkg::VOL_W-1:0]  in_bid_volume,
  input  logic [plit_pkg::VOL_W-1:0]  in_ask_volume,
  input  logic [plit_pkg::TICK_W-1:0] base_tick,
  output plit_pkg::item_t             item
);

  logic [plit_pkg::TICK_W:0] diff;
  logic                      oor;

  always_comb begin
    diff = {1'b0, in_price_tick} - {1'b0, base_tick};
    // borrow out means tick below base
    oor  = diff[plit_pkg::TICK_W] ||
           (diff[plit_pkg::TICK_W-1:0] >= plit_pkg::TICK_W'(plit_pkg::LEVELS));
    item.slot = diff[plit_pkg::SLOT_W-1:0];
    item.bid  = in_bid_volume;
    item.ask  = in_ask_volume;
    if (in_command) begin
      item.kind = plit_pkg::KIND_CLEAR;
    end else if (oor) begin
      item.kind = plit_pkg::KIND_OOR;
    end else begin
      item.kind = plit_pkg::KIND_ADD;
    end
  end

endmodule

@@ hdl/plit_queue.sv @@
// ---------------------------------------------------------------------------
// plit_queue
// short queue of classified words between front and back
// ---------------------------------------------------------------------------
module plit_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  plit_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output plit_pkg::item_t rd_item,
  output logic            not_empty
);

  plit_pkg::item_t                mem_r [plit_pkg::QDEPTH];
  logic [plit_pkg::QPTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [plit_pkg::QPTR_W:0]      cnt_r, cnt_nxt;
  logic                           do_wr, do_rd;

  assign full      = (cnt_r == (plit_pkg::QPTR_W+1)'(plit_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (plit_pkg::QPTR_W+1)'(do_wr) - (plit_pkg::QPTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

@@ hdl/plit_back.sv @@
// ---------------------------------------------------------------------------
// plit_back
// level table: clearing pass on reset and new bar; else read three slots, sum, test ratios, write back, emit result
// ---------------------------------------------------------------------------
module plit_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [plit_pkg::THR_W-1:0] threshold,
  input  logic                       q_valid,
  input  plit_pkg::item_t            q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  output plit_pkg::result_t          out_res,
  input  logic                       out_take
);

  localparam int SW = plit_pkg::SLOT_W;
  localparam int TW = plit_pkg::TOT_W;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_CMP  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SW:0]       cnt_r, cnt_nxt;
  logic              emit_r, emit_nxt;
  logic              vld_r, vld_nxt;
  plit_pkg::result_t res_r, res_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [SW-1:0]     low_r, low_nxt, high_r, high_nxt;
  plit_pkg::item_t   it_r, it_nxt;
  logic [TW-1:0]     bsum_r, bsum_nxt, asum_r, asum_nxt;
  logic [TW-1:0]     dlo_r, dlo_nxt, dhi_r, dhi_nxt;
  logic              obuy_r, obuy_nxt, osell_r, osell_nxt;

  // memory ports
  logic                        we;
  logic [SW-1:0]               waddr, ra_c, ra_lo, ra_hi;
  logic [plit_pkg::ROW_W-1:0]  wrow, rrow;
  logic [TW-1:0]               wbid, wask, rbid_lo, rask_hi;

  // compare datapath
  logic [TW:0]   bs_full, as_full;
  logic [TW+plit_pkg::THR_W-1:0] lhs_buy, lhs_sell, rhs_buy, rhs_sell;
  logic          t_buy, t_sell, nbuy, nsell;

  plit_ram #(.WIDTH(plit_pkg::ROW_W), .DEPTH(plit_pkg::LEVELS)) u_ram_c (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrow), .raddr(ra_c), .rdata(rrow));
  plit_ram #(.WIDTH(TW), .DEPTH(plit_pkg::LEVELS)) u_ram_lo (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wbid), .raddr(ra_lo), .rdata(rbid_lo));
  plit_ram #(.WIDTH(TW), .DEPTH(plit_pkg::LEVELS)) u_ram_hi (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wask), .raddr(ra_hi), .rdata(rask_hi));

  assign ra_c  = q_item.slot;
  assign ra_lo = q_item.slot - 1'b1;
  assign ra_hi = q_item.slot + 1'b1;

  always_comb begin
    bs_full  = {1'b0, rrow[plit_pkg::ROW_W-1 -: TW]} + (TW+1)'(it_r.bid);
    as_full  = {1'b0, rrow[TW+1 -: TW]} + (TW+1)'(it_r.ask);
    // ratio test: num*10 >= threshold*max(den,1)
    lhs_buy  = (TW+plit_pkg::THR_W)'({asum_r, 3'b000}) +
               (TW+plit_pkg::THR_W)'({asum_r, 1'b0});
    lhs_sell = (TW+plit_pkg::THR_W)'({bsum_r, 3'b000}) +
               (TW+plit_pkg::THR_W)'({bsum_r, 1'b0});
    rhs_buy  = threshold * dlo_r;
    rhs_sell = threshold * dhi_r;
    t_buy    = (it_r.slot != low_r) && (it_r.slot != '0);
    t_sell   = (it_r.slot != high_r) && (it_r.slot != SW'(plit_pkg::LEVELS - 1));
    nbuy     = obuy_r  || (t_buy  && (lhs_buy  >= rhs_buy));
    nsell    = osell_r || (t_sell && (lhs_sell >= rhs_sell));
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    emit_nxt     = emit_r;
    vld_nxt      = vld_r && !out_take;
    res_nxt      = res_r;
    nonempty_nxt = nonempty_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    it_nxt       = it_r;
    bsum_nxt     = bsum_r;
    asum_nxt     = asum_r;
    dlo_nxt      = dlo_r;
    dhi_nxt      = dhi_r;
    obuy_nxt     = obuy_r;
    osell_nxt    = osell_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = it_r.slot;
    wbid         = bsum_r;
    wask         = asum_r;
    wrow         = {bsum_r, asum_r, nbuy, nsell};
    unique case (state_r)
      ST_CLR: begin
        we           = 1'b1;
        waddr        = cnt_r[SW-1:0];
        wbid         = '0;
        wask         = '0;
        wrow         = '0;
        cnt_nxt      = cnt_r + 1'b1;
        nonempty_nxt = 1'b0;
        low_nxt      = '0;
        high_nxt     = '0;
        if (cnt_r == (SW+1)'(plit_pkg::LEVELS - 1)) begin
          state_nxt = ST_IDLE;
          if (emit_r) begin
            vld_nxt = 1'b1;
            res_nxt = '0;
          end
          emit_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        // start once the result slot is free or being taken
        if (q_valid && (!vld_r || out_take)) begin
          q_pop  = 1'b1;
          it_nxt = q_item;
          unique case (q_item.kind)
            plit_pkg::KIND_CLEAR: begin
              state_nxt = ST_CLR;
              cnt_nxt   = '0;
              emit_nxt  = 1'b1;
            end
            plit_pkg::KIND_OOR: begin
              vld_nxt = 1'b1;
              res_nxt = '0;
              res_nxt.oor = 1'b1;
            end
            default: begin
              state_nxt = ST_SUM;
            end
          endcase
        end
      end
      ST_SUM: begin
        bsum_nxt  = bs_full[TW] ? '1 : bs_full[TW-1:0];
        asum_nxt  = as_full[TW] ? '1 : as_full[TW-1:0];
        dlo_nxt   = (rbid_lo == '0) ? TW'(1) : rbid_lo;
        dhi_nxt   = (rask_hi == '0) ? TW'(1) : rask_hi;
        obuy_nxt  = rrow[1];
        osell_nxt = rrow[0];
        if (!nonempty_r) begin
          nonempty_nxt = 1'b1;
          low_nxt      = it_r.slot;
          high_nxt     = it_r.slot;
        end else begin
          if (it_r.slot < low_r)  low_nxt  = it_r.slot;
          if (it_r.slot > high_r) high_nxt = it_r.slot;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        we        = 1'b1;
        vld_nxt   = 1'b1;
        res_nxt   = '{bid_total: bsum_r, ask_total: asum_r,
                      buy: nbuy, sell: nsell, oor: 1'b0};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      cnt_r      <= '0;
      emit_r     <= 1'b0;
      vld_r      <= 1'b0;
      nonempty_r <= 1'b0;
      low_r      <= '0;
      high_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      emit_r     <= emit_nxt;
      vld_r      <= vld_nxt;
      nonempty_r <= nonempty_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
    end
    res_r   <= res_nxt;
    it_r    <= it_nxt;
    bsum_r  <= bsum_nxt;
    asum_r  <= asum_nxt;
    dlo_r   <= dlo_nxt;
    dhi_r   <= dhi_nxt;
    obuy_r  <= obuy_nxt;
    osell_r <= osell_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

  a_cmp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |=> state_r == ST_IDLE && vld_r)
    else $error("compare step did not deliver a word");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r |-> low_r <= high_r)
    else $error("lowest slot above highest slot");

  a_clr_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR |-> !q_pop && we)
    else $error("queue popped during clear pass");

  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE && (!vld_r || out_take))
    else $error("item taken with result slot busy");

endmodule

@@ hdl/price_level_imbalance_table.sv @@
// ---------------------------------------------------------------------------
// price_level_imbalance_table
// per-bar table of price levels with saturating volumes and imbalance flags
// ---------------------------------------------------------------------------
// input words enter on push/full, results leave on empty/pop, one result per
// word, in order. configuration (base tick, threshold) is written on cfg_we;
// the user must write it only while the block is idle, the block itself does
// not enforce this. in the back end an add word passes table read, sum, then
// ratio test and write back; the table memories have registered reads. a
// two-entry queue lets the input side keep taking words while the back end
// works. an out-of-window word gives its result straight from idle, with no
// table access. a new-bar word, and reset, run a clearing pass over all
// LEVELS table rows, one row a cycle; no word is taken from the queue
// during it. reset returns no result. when the receiver does not pop, the
// result waits on the out_ ports, the back end holds, and full rises once
// the queue has filled.
// ---------------------------------------------------------------------------
module price_level_imbalance_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_command,
  input  logic [plit_pkg::TICK_W-1:0] in_price_tick,
  input  logic [plit_pkg::VOL_W-1:0]  in_bid_volume,
  input  logic [plit_pkg::VOL_W-1:0]  in_ask_volume,
  output logic                        empty,
  input  logic                        pop,
  output logic [plit_pkg::TOT_W-1:0]  out_bid_total,
  output logic [plit_pkg::TOT_W-1:0]  out_ask_total,
  output logic                        out_buy_imbalance,
  output logic                        out_sell_imbalance,
  output logic                        out_out_of_range,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [plit_pkg::TICK_W-1:0] cfg_data
);

  logic [plit_pkg::TICK_W-1:0] base_r;
  logic [plit_pkg::THR_W-1:0]  thr_r;
  plit_pkg::item_t             f_item, q_item;
  logic                        q_valid, q_pop, o_valid;
  plit_pkg::result_t           o_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      thr_r  <= plit_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plit_pkg::CFG_BASE_TICK: base_r <= cfg_data;
        plit_pkg::CFG_THRESHOLD: thr_r  <= cfg_data[plit_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  plit_front u_front (
    .in_command(in_command), .in_price_tick(in_price_tick),
    .in_bid_volume(in_bid_volume), .in_ask_volume(in_ask_volume),
    .base_tick(base_r), .item(f_item));

  plit_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_item(f_item), .full(full),
    .rd_en(q_pop), .rd_item(q_item), .not_empty(q_valid));

  plit_back u_back (
    .clk(clk), .rst_n(rst_n), .threshold(thr_r), .q_valid(q_valid),
    .q_item(q_item), .q_pop(q_pop), .out_valid(o_valid), .out_res(o_res),
    .out_take(pop));

  assign empty              = !o_valid;
  assign out_bid_total      = o_res.bid_total;
  assign out_ask_total      = o_res.ask_total;
  assign out_buy_imbalance  = o_res.buy;
  assign out_sell_imbalance = o_res.sell;
  assign out_out_of_range   = o_res.oor;

endmodule
